@@ rtl/exp_golomb_order_k_codec_macros.svh @@
// assertion macros shared by the codec checker
`ifndef EXP_GOLOMB_ORDER_K_CODEC_MACROS_SVH
`define EXP_GOLOMB_ORDER_K_CODEC_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EGK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("egk check failed");

// next-cycle implication, disabled while reset is low
`define EGK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("egk check failed");

// next-cycle implication that also watches the reset itself
`define EGK_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("egk check failed");

`endif

@@ rtl/egk_pkg.sv @@
// types, constants and helper functions of the exp-golomb codec
package egk_pkg;

    localparam int VAL_IN_BITS = 16;
    localparam int W_BITS      = VAL_IN_BITS + 1;
    localparam int F_BITS      = 5;
    localparam int K_BITS      = 4;
    localparam int CW_BITS     = 48;
    localparam int LEN_BITS    = 6;
    localparam int DV_BITS     = 32;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [VAL_IN_BITS-1:0] value;
        logic                   code_bit;
    } t_req;

    typedef struct packed {
        logic [CW_BITS-1:0]  codeword;
        logic [LEN_BITS-1:0] code_length;
        logic [DV_BITS-1:0]  decoded_value;
        logic                decode_done;
        logic                prefix_error;
    } t_rsp;

    // decoder outcome for one code bit
    typedef struct packed {
        logic               hit;
        logic               done;
        logic               err;
        logic [DV_BITS-1:0] value;
    } t_dec_res;

    // position of the leading one, 0 for w of 0 or 1
    function automatic logic [F_BITS-1:0] lead_one(input logic [W_BITS-1:0] w);
        logic [F_BITS-1:0] p;
        p = '0;
        for (int i = 1; i < W_BITS; i++) begin
            if (w[i]) begin
                p = F_BITS'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/egk_enc.sv @@
// exp-golomb encoder datapath: leading-one detect and codeword packing
module egk_enc #(
    parameter int VALUE_BITS = 16
) (
    input  logic [egk_pkg::VAL_IN_BITS-1:0] i_value,
    input  logic [egk_pkg::K_BITS-1:0]      i_order_k,
    output logic [egk_pkg::CW_BITS-1:0]     o_codeword,
    output logic [egk_pkg::LEN_BITS-1:0]    o_code_length
);
    import egk_pkg::*;

    localparam logic [VAL_IN_BITS-1:0] VMASK = (VALUE_BITS >= VAL_IN_BITS) ?
        {VAL_IN_BITS{1'b1}} : VAL_IN_BITS'((33'd1 << VALUE_BITS) - 33'd1);

    logic [VAL_IN_BITS-1:0] n;
    logic [VAL_IN_BITS-1:0] kmask;
    logic [W_BITS-1:0]      w;
    logic [F_BITS-1:0]      f;
    logic [LEN_BITS-1:0]    slen;
    logic [CW_BITS-1:0]     body;
    logic [CW_BITS-1:0]     prefix;

    always_comb begin
        n     = i_value & VMASK;
        kmask = VAL_IN_BITS'((17'd1 << i_order_k) - 17'd1);
        w     = {1'b0, n >> i_order_k} + W_BITS'(1);
        f     = lead_one(w);
        slen  = LEN_BITS'(f) + LEN_BITS'(i_order_k);
        // w still has its leading one at slen; the prefix mask flips it to the stop zero
        body   = (CW_BITS'(w) << i_order_k) | CW_BITS'(n & kmask);
        prefix = ((CW_BITS'(1) << (LEN_BITS'(f) + LEN_BITS'(1))) - CW_BITS'(1)) << slen;
        o_codeword    = body ^ prefix;
        o_code_length = {f, 1'b1} + LEN_BITS'(i_order_k);
    end

endmodule

@@ rtl/egk_dec.sv @@
// exp-golomb bit-serial decoder state and next-state logic
module egk_dec #(
    parameter int MAX_PREFIX = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_bit,
    input  logic [egk_pkg::K_BITS-1:0] i_order_k,
    output egk_pkg::t_dec_res          o_res
);
    import egk_pkg::*;

    localparam int PW  = $clog2(MAX_PREFIX + 2);
    localparam int BLW = $clog2(MAX_PREFIX + 16);
    localparam logic [PW-1:0] PMAX = PW'(MAX_PREFIX);

    logic               r_collecting, n_collecting;
    logic [PW-1:0]      r_prefix, n_prefix;
    logic [BLW-1:0]     r_bits_left, n_bits_left;
    logic [DV_BITS-1:0] r_acc, n_acc;

    logic [PW-1:0]      prefix_inc;
    logic [BLW-1:0]     bits_dec;
    logic [DV_BITS-1:0] acc_new;
    logic [DV_BITS:0]   ones_mask;
    logic [DV_BITS-1:0] base;

    always_comb begin
        prefix_inc = r_prefix + PW'(1);
        bits_dec   = r_bits_left - BLW'(1);
        acc_new    = {r_acc[DV_BITS-2:0], i_bit};
        ones_mask  = ((DV_BITS+1)'(1) << r_prefix) - (DV_BITS+1)'(1);
        base       = ones_mask[DV_BITS-1:0] << i_order_k;

        n_collecting = r_collecting;
        n_prefix     = r_prefix;
        n_bits_left  = r_bits_left;
        n_acc        = r_acc;
        o_res        = '0;

        if (i_fire) begin
            if (!r_collecting) begin
                if (i_bit) begin
                    if (prefix_inc > PMAX) begin
                        // overlong prefix: flag it and start over
                        n_prefix  = '0;
                        o_res.hit = 1'b1;
                        o_res.err = 1'b1;
                    end else begin
                        n_prefix = prefix_inc;
                    end
                end else if (r_prefix == '0 && i_order_k == '0) begin
                    // empty suffix completes on the stop bit
                    o_res.hit  = 1'b1;
                    o_res.done = 1'b1;
                end else begin
                    n_collecting = 1'b1;
                    n_bits_left  = BLW'(r_prefix) + BLW'(i_order_k);
                    n_acc        = '0;
                end
            end else begin
                n_acc = acc_new;
                if (bits_dec == '0) begin
                    o_res.hit    = 1'b1;
                    o_res.done   = 1'b1;
                    o_res.value  = base + acc_new;
                    n_collecting = 1'b0;
                    n_prefix     = '0;
                    n_bits_left  = '0;
                    n_acc        = '0;
                end else begin
                    n_bits_left = bits_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_prefix     <= '0;
            r_bits_left  <= '0;
            r_acc        <= '0;
        end else begin
            r_collecting <= n_collecting;
            r_prefix     <= n_prefix;
            r_bits_left  <= n_bits_left;
            r_acc        <= n_acc;
        end
    end

endmodule

@@ rtl/exp_golomb_order_k_codec.sv @@
// top level of the order-k exp-golomb encoder and bit-serial decoder
//
// input channel (i_in_valid / o_in_ready / i_in_data) takes one request per
// cycle while o_in_ready is high: func encode packs a value into a codeword
// and always answers; func decode feeds one code bit and answers only when a
// codeword completes or when the prefix runs past MAX_PREFIX ones
// output channel (o_out_valid / i_out_ready / o_out_data) carries the answers
// in request order
// a request accepted into the input register is worked out by the encoder or
// decoder logic, and its answer, if any, lands in the result register
// throughput: one request per cycle while the receiver is not stalling, set
// by the single compute stage between the two registers; the decoder state
// updates once per code bit
// a stalled receiver holds the result register; the input register still
// takes one more request, after which o_in_ready drops until it moves on
// order_k is written through i_cfg_we / i_cfg_wdata; the user must do so only
// while no request is in flight, as the block itself does not enforce it
// reset (synchronous, active low) clears both valid flags, order_k and the
// decoder state; o_in_ready is low while reset is held
module exp_golomb_order_k_codec #(
    parameter int VALUE_BITS = 16,
    parameter int MAX_PREFIX = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  egk_pkg::t_req              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output egk_pkg::t_rsp              o_out_data,
    input  logic                       i_cfg_we,
    input  logic [egk_pkg::K_BITS-1:0] i_cfg_wdata
);
    import egk_pkg::*;

    logic [K_BITS-1:0]   r_order_k;
    logic                r_in_vld;
    t_req                r_req;
    logic                r_out_vld;
    t_rsp                r_rsp, n_rsp;

    logic                out_adv;
    logic                produce;
    logic                dec_fire;
    logic [CW_BITS-1:0]  enc_cw;
    logic [LEN_BITS-1:0] enc_len;
    t_dec_res            dec_res;

    // result register is free or draining this cycle
    assign out_adv    = !r_out_vld || i_out_ready;
    assign o_in_ready = i_rst_n && (!r_in_vld || out_adv);
    assign dec_fire   = r_in_vld && out_adv && (r_req.func == FUNC_DECODE);

    egk_enc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_egk_enc (
        .i_value       (r_req.value),
        .i_order_k     (r_order_k),
        .o_codeword    (enc_cw),
        .o_code_length (enc_len)
    );

    egk_dec #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_egk_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (dec_fire),
        .i_bit     (r_req.code_bit),
        .i_order_k (r_order_k),
        .o_res     (dec_res)
    );

    // pick the answer for the request in the input register
    always_comb begin
        n_rsp = '0;
        if (r_req.func == FUNC_ENCODE) begin
            n_rsp.codeword    = enc_cw;
            n_rsp.code_length = enc_len;
            produce           = 1'b1;
        end else begin
            n_rsp.decoded_value = dec_res.value;
            n_rsp.decode_done   = dec_res.done;
            n_rsp.prefix_error  = dec_res.err;
            produce             = dec_res.hit;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_k <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order_k <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld && produce;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_data;
        end
        if (out_adv && r_in_vld && produce) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_rsp;

endmodule

@@ rtl/egk_chk.sv @@
// port-level checker for the exp-golomb codec and its bind
`include "exp_golomb_order_k_codec_macros.svh"

module egk_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input egk_pkg::t_rsp o_out_data
);
    import egk_pkg::*;

    // reset leaves no result pending and the input open once released
    `EGK_ASSERT_NEXT_ALWAYS(a_reset_clears, !i_rst_n, !o_out_valid && (o_in_ready || !i_rst_n))

    // an empty result register never blocks the input side
    `EGK_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)

    // every result is exactly one of encode, decode done or prefix error
    `EGK_ASSERT_NOW(a_one_kind, o_out_valid,
        $onehot({o_out_data.decode_done, o_out_data.prefix_error,
                 o_out_data.code_length != '0}))

    // an error result carries nothing else
    `EGK_ASSERT_NOW(a_error_clean, o_out_valid && o_out_data.prefix_error,
        o_out_data.codeword == '0 && o_out_data.decoded_value == '0)

    // a stalled result holds
    `EGK_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data))

endmodule

bind exp_golomb_order_k_codec egk_chk u_egk_chk (.*);

@@ verif/tb.sv @@
// self-checking testbench for the order-k exp-golomb encoder and bit-serial decoder
`timescale 1ns / 1ps

module tb;
    import egk_pkg::*;

    localparam int VALUE_W     = 16;
    localparam int PREFIX_MAX  = 16;
    localparam int RANDOM_REQS = 1500;
    localparam int PHASE_REQS  = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 4;

    typedef enum {ROW_ORDER, ROW_ENCODE, ROW_DECODE} t_row_kind;

    // one line of the directed script; want only counts when typed is set
    typedef struct {
        t_row_kind kind;
        int        arg;
        int        reps;
        bit        typed;
        t_rsp      want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_req                i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    t_rsp                o_out_data;
    logic                i_cfg_we;
    logic [K_BITS-1:0]   i_cfg_wdata;

    // predictor state: order register plus the decoder's view of the bitstream
    logic [3:0]  golomb_k;
    bit          dec_gathering;
    int          dec_ones;
    int          dec_left;
    logic [63:0] dec_acc;

    t_rsp        expect_q[$];
    logic        carry_bits[$];
    t_row        script[$];

    int          burst_left;
    int          req_count;
    int          results_seen;
    int          done_count;
    int          overrun_count;
    int          order_writes;
    int          in_stall_cycles;
    int          mismatches;
    int          idle_cycles;
    bit          hold_off_go;
    bit          hold_done;

    exp_golomb_order_k_codec #(
        .VALUE_BITS (VALUE_W),
        .MAX_PREFIX (PREFIX_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // codeword for value n at order k: f ones, a zero, low f bits of w, low k bits of n
    function automatic t_rsp encode_value(input logic [15:0] n, input logic [3:0] k);
        logic [16:0] w;
        logic [63:0] ones_mask;
        logic [63:0] low_k;
        logic [63:0] code;
        int          f;
        t_rsp        r;
        w = ({1'b0, n} >> k) + 17'd1;
        // leading one of w sets the prefix length
        f = 0;
        for (int i = 16; i > 0; i--) begin
            if (f == 0 && w[i]) begin
                f = i;
            end
        end
        ones_mask = (64'd1 << f) - 64'd1;
        low_k     = (64'd1 << k) - 64'd1;
        code      = ((64'(w) & ones_mask) << k) | (64'(n) & low_k);
        code      = code | (ones_mask << (f + k + 1));
        r               = '0;
        r.codeword      = code[47:0];
        r.code_length   = 6'(2 * f + 1 + k);
        return r;
    endfunction

    function automatic void clear_decoder();
        dec_gathering = 1'b0;
        dec_ones      = 0;
        dec_left      = 0;
        dec_acc       = '0;
    endfunction

    // advances the predicted codec by one request, returns 1 when it answers
    function automatic bit codec_step(input t_req r, output t_rsp rsp);
        logic [63:0] val;
        rsp = '0;
        if (r.func == FUNC_ENCODE) begin
            rsp = encode_value(r.value, golomb_k);
            return 1'b1;
        end
        if (!dec_gathering) begin
            if (r.code_bit) begin
                dec_ones++;
                // prefix overrun: flag it and start over
                if (dec_ones > PREFIX_MAX) begin
                    clear_decoder();
                    rsp.prefix_error = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            // empty suffix completes on the terminating zero
            if (dec_ones + golomb_k == 0) begin
                clear_decoder();
                rsp.decode_done = 1'b1;
                return 1'b1;
            end
            dec_gathering = 1'b1;
            dec_left      = dec_ones + golomb_k;
            dec_acc       = '0;
            return 1'b0;
        end
        dec_acc = (dec_acc << 1) | 64'(r.code_bit);
        if (dec_left > 0) begin
            dec_left--;
        end
        if (dec_left == 0) begin
            // order in force now, not when the prefix ended
            val = (((64'd1 << dec_ones) - 64'd1) << golomb_k) + dec_acc;
            clear_decoder();
            rsp.decode_done   = 1'b1;
            rsp.decoded_value = val[31:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_rsp result_of(input logic [47:0] cw, input logic [5:0] len,
                                       input logic [31:0] dv, input bit done, input bit err);
        t_rsp r;
        r.codeword      = cw;
        r.code_length   = len;
        r.decoded_value = dv;
        r.decode_done   = done;
        r.prefix_error  = err;
        return r;
    endfunction

    function automatic t_row row(input t_row_kind kind, input int arg, input int reps,
                                 input bit typed, input t_rsp want);
        t_row x;
        x.kind  = kind;
        x.arg   = arg;
        x.reps  = reps;
        x.typed = typed;
        x.want  = want;
        return x;
    endfunction

    // unused fields get random content so their bits toggle too
    function automatic t_req enc_req(input logic [15:0] n);
        t_req r;
        r.func     = FUNC_ENCODE;
        r.value    = n;
        r.code_bit = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_req dec_req(input logic b);
        t_req r;
        r.func     = FUNC_DECODE;
        r.value    = 16'($urandom_range(0, 65535));
        r.code_bit = b;
        return r;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 15));
            1: return 16'(65535 - $urandom_range(0, 3));
            default: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // called at a falling edge; holds the request until the block takes it
    task automatic send_req(input t_req r, input bit typed, input t_rsp want);
        t_rsp rsp;
        bit   answers;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        answers = codec_step(r, rsp);
        if (typed) begin
            expect_q.push_back(want);
        end else if (answers) begin
            expect_q.push_back(rsp);
        end
        req_count++;
        @(negedge i_clk);
    endtask

    // sender runs in bursts; a gap, when drawn, opens each new burst
    task automatic offer(input t_req r, input bit typed = 1'b0, input t_rsp want = '0);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: gap = 0;
                4:          gap = $urandom_range(10, 20);
                default:    gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        send_req(r, typed, want);
    endtask

    // order_k only changes with nothing in flight
    task automatic write_order(input logic [3:0] k);
        i_in_valid <= 1'b0;
        while (expect_q.size() != 0) @(negedge i_clk);
        // a trailing decode bit may still be in the pipe without an answer
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        golomb_k     = k;
        burst_left   = 0;
        order_writes++;
    endtask

    // feeds a codeword bit by bit; a split leaves the tail for the next phase
    task automatic feed_codeword(input logic [15:0] n, input bit split);
        t_rsp enc;
        int   len;
        int   stop;
        enc  = encode_value(n, golomb_k);
        len  = int'(enc.code_length);
        stop = (split && len > 1) ? $urandom_range(1, len - 1) : len;
        for (int i = len - 1; i >= 0; i--) begin
            if (len - 1 - i < stop) begin
                // encode requests may land in the middle of a codeword
                if (!split && $urandom_range(0, 9) == 0) begin
                    offer(enc_req(pick_value()));
                end
                offer(dec_req(enc.codeword[i]));
            end else begin
                carry_bits.push_back(enc.codeword[i]);
            end
        end
    endtask

    task automatic run_segment();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            offer(enc_req(pick_value()));
        end else if (sel < 8) begin
            feed_codeword(pick_value(), 1'b0);
        end else if (sel == 8) begin
            // loose bits that desync the stream
            repeat ($urandom_range(1, 8)) offer(dec_req(1'($urandom_range(0, 1))));
        end else begin
            // prefix around the overrun limit
            repeat ($urandom_range(15, 18)) offer(dec_req(1'b1));
        end
    endtask

    // receiver: runs of steady, random or stalled ready, plus one long hold-off
    initial begin : receiver
        int mode;
        int span;
        i_out_ready = 1'b0;
        forever begin
            if (hold_off_go && !hold_done) begin
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(1, 40);
                repeat (span) begin
                    @(negedge i_clk);
                    case (mode)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= 1'($urandom_range(0, 1));
                        2:       i_out_ready <= ($urandom_range(0, 7) != 0);
                        default: i_out_ready <= (span > 8);
                    endcase
                end
            end
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expect_q.size() == 0) begin
                $error("result with no request waiting for one: %h", o_out_data);
                mismatches++;
            end else begin
                want = expect_q.pop_front();
                check_field("codeword", 64'(want.codeword), 64'(o_out_data.codeword));
                check_field("code_length", 64'(want.code_length),
                            64'(o_out_data.code_length));
                check_field("decoded_value", 64'(want.decoded_value),
                            64'(o_out_data.decoded_value));
                check_field("decode_done", 64'(want.decode_done),
                            64'(o_out_data.decode_done));
                check_field("prefix_error", 64'(want.prefix_error),
                            64'(o_out_data.prefix_error));
                results_seen++;
                if (want.decode_done) begin
                    done_count++;
                end
                if (want.prefix_error) begin
                    overrun_count++;
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_ready) begin
            in_stall_cycles++;
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus: reset, directed script, then random phases, each opened by an order write
    initial begin : stimulus
        int   phase_end;
        int   phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        golomb_k    = '0;
        clear_decoder();
        burst_left  = 0;
        hold_off_go = 1'b0;
        hold_done   = 1'b0;

        // extremes at order 0 straight out of reset
        script.push_back(row(ROW_ENCODE, 0, 1, 1'b1, result_of(48'h0, 6'd1, 32'd0, 0, 0)));
        script.push_back(row(ROW_ENCODE, 65535, 1, 1'b1,
                             result_of(48'h1_FFFE_0000, 6'd33, 32'd0, 0, 0)));
        script.push_back(row(ROW_ENCODE, 1, 1, 1'b0, '0));
        // lone zero at order 0 is a complete codeword for 0
        script.push_back(row(ROW_DECODE, 0, 1, 1'b1, result_of(48'h0, 6'd0, 32'd0, 1, 0)));
        // one prefix bit too many trips the overrun flag
        script.push_back(row(ROW_DECODE, 1, PREFIX_MAX + 1, 1'b1,
                             result_of(48'h0, 6'd0, 32'd0, 0, 1)));
        // largest order
        script.push_back(row(ROW_ORDER, 15, 1, 1'b0, '0));
        script.push_back(row(ROW_ENCODE, 65535, 1, 1'b0, '0));
        script.push_back(row(ROW_ENCODE, 0, 1, 1'b1, result_of(48'h0, 6'd16, 32'd0, 0, 0)));
        // order switched while the decoder sits inside a codeword
        script.push_back(row(ROW_ORDER, 1, 1, 1'b0, '0));
        script.push_back(row(ROW_DECODE, 0, 1, 1'b0, '0));
        script.push_back(row(ROW_ORDER, 15, 1, 1'b0, '0));
        script.push_back(row(ROW_DECODE, 1, 1, 1'b0, '0));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_ORDER: begin
                    write_order(4'(script[i].arg));
                end
                ROW_ENCODE: begin
                    for (int j = 0; j < script[i].reps; j++) begin
                        offer(enc_req(16'(script[i].arg)),
                              script[i].typed && j == script[i].reps - 1, script[i].want);
                    end
                end
                default: begin
                    for (int j = 0; j < script[i].reps; j++) begin
                        offer(dec_req(1'(script[i].arg)),
                              script[i].typed && j == script[i].reps - 1, script[i].want);
                    end
                end
            endcase
        end

        phase_end = req_count;
        phase     = 0;
        while (req_count < phase_end + RANDOM_REQS) begin
            if (phase == 0) begin
                write_order(4'd0);
                // receiver backs off for a while during the first phase
                hold_off_go = 1'b1;
            end else if (phase == 1) begin
                write_order(4'd15);
            end else begin
                write_order(4'($urandom_range(0, 15)));
            end
            // finish the codeword cut off by the last phase under the new order
            while (carry_bits.size() != 0) begin
                offer(dec_req(carry_bits.pop_front()));
            end
            begin : phase_body
                int stop_at;
                stop_at = req_count + PHASE_REQS;
                while (req_count < stop_at) run_segment();
            end
            if ($urandom_range(0, 1) == 1) begin
                feed_codeword(pick_value(), 1'b1);
            end
            phase++;
        end

        // drain and let any late result show up
        i_in_valid <= 1'b0;
        while (expect_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("covered %0d requests, %0d results, %0d decoded codewords, %0d overruns",
                 req_count, results_seen, done_count, overrun_count);
        $display("order writes %0d, input stall cycles %0d, mismatches %0d",
                 order_writes, in_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
